/* rtl/slpm_pkg.sv */
// Shared types and constants for the stage latency percentile monitor.
package slpm_pkg;

    localparam int DUR_W      = 32;
    localparam int COUNT_W    = 7;
    localparam int STAGE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int BUDGET_W   = 32;
    localparam int NUM_BUDGET_STAGES = 4;

    localparam int Q95 = 95;
    localparam int Q99 = 99;
    localparam int QSCALE = 100;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_P95 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_P99 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIT_P95    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIT_P99    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_P95    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_P99    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLVER_P95  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLVER_P99  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_CAPV,
        S_SCAN,
        S_JUDGE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic [COUNT_W-1:0] count;
        logic [DUR_W-1:0]   p95;
        logic [DUR_W-1:0]   p99;
    } t_res;

endpackage

/* rtl/slpm_store.sv */
// Sample memory: one write port, one read port with registered read data.
module slpm_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [slpm_pkg::DUR_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [slpm_pkg::DUR_W-1:0]  o_rdata
);
    import slpm_pkg::*;

    logic [DUR_W-1:0] r_mem [DEPTH];
    logic [DUR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/slpm_ctrl.sv */
// Sequencer: ring pointers, record writes and rank selection with one comparator.
module slpm_ctrl #(
    parameter int WINDOW     = 64,
    parameter int NUM_STAGES = 4,
    parameter int AW         = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_opcode,
    input  logic [slpm_pkg::STAGE_W-1:0]  i_stage,
    input  logic [slpm_pkg::DUR_W-1:0]    i_duration,
    output logic                          o_ready,
    output logic                          o_res_valid,
    output slpm_pkg::t_res                o_res,
    input  logic                          i_res_take,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [slpm_pkg::DUR_W-1:0]    o_wdata,
    output logic [AW-1:0]                 o_raddr,
    input  logic [slpm_pkg::DUR_W-1:0]    i_rdata
);
    import slpm_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PW    = $clog2(2 * WINDOW);
    localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int CW    = $clog2(QSCALE * WINDOW + 1);
    localparam logic [PW-1:0]    WIN_P  = PW'(WINDOW);
    localparam logic [CW-1:0]    C_SCL  = CW'(QSCALE);
    localparam logic [CW-1:0]    C_Q95  = CW'(Q95);
    localparam logic [CW-1:0]    C_Q99  = CW'(Q99);
    localparam logic [CNT_W-1:0] CNT_WIN = CNT_W'(WINDOW);

    function automatic logic [IDX_W-1:0] wrap_pos(input logic [PW-1:0] a);
        logic [PW-1:0] r;
        r = (a >= WIN_P) ? a - WIN_P : a;
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [AW-1:0] row_addr(input logic [SW-1:0] s,
                                               input logic [IDX_W-1:0] p);
        return AW'(int'(s) * WINDOW) + AW'(p);
    endfunction

    t_state r_state, n_state;

    logic [IDX_W-1:0] r_wp  [NUM_STAGES];
    logic [CNT_W-1:0] r_cnt [NUM_STAGES];

    logic [SW-1:0]      r_st;
    logic [STAGE_W-1:0] r_stage;
    logic [CNT_W-1:0]   r_n, r_i, r_j, r_less, r_le;
    logic [IDX_W-1:0]   r_base;
    logic [DUR_W-1:0]   r_v, r_p95, r_p99;
    logic [CW-1:0]      r_qn95, r_qn99;
    logic               r_got95, r_got99;

    logic [2:0]       st3;
    logic [SW-1:0]    st_idx;
    logic             stage_ok;
    logic [IDX_W-1:0] cur_wp;
    logic [CNT_W-1:0] cur_cnt, n_eff;
    logic             is_query, is_record;
    logic             f95, f99, all_found, last_cand;
    logic [CW-1:0]    less_s, le_s;
    logic [31:0]      n32;

    assign st3      = {1'b0, i_stage};
    assign st_idx   = st3[SW-1:0];
    assign stage_ok = int'(i_stage) < NUM_STAGES;
    assign cur_wp   = r_wp[st_idx];
    assign cur_cnt  = r_cnt[st_idx];
    assign n_eff    = stage_ok ? cur_cnt : '0;
    assign is_query  = i_start && (i_opcode == OP_QUERY);
    assign is_record = i_start && (i_opcode == OP_RECORD) && stage_ok;

    // rank test scaled by 100: less < ceil(q*n/100) <= le
    assign less_s    = CW'(r_less) * C_SCL;
    assign le_s      = CW'(r_le) * C_SCL;
    assign f95       = (less_s < r_qn95) && (r_qn95 <= le_s);
    assign f99       = (less_s < r_qn99) && (r_qn99 <= le_s);
    assign all_found = (r_got95 || f95) && (r_got99 || f99);
    assign last_cand = (r_i + CNT_W'(1)) == r_n;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_state = (n_eff == '0) ? S_DONE : S_CAND;
                end
            end
            S_CAND:  n_state = S_CAPV;
            S_CAPV:  n_state = S_SCAN;
            S_SCAN: begin
                if (r_j == r_n) begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: n_state = (all_found || last_cand) ? S_DONE : S_CAND;
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_raddr     = row_addr(r_st, r_base);
        case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_CAND:  o_raddr = row_addr(r_st, wrap_pos(PW'(r_base) + PW'(r_i)));
            S_CAPV:  o_raddr = row_addr(r_st, r_base);
            S_SCAN:  o_raddr = row_addr(r_st, wrap_pos(PW'(r_base) + PW'(r_j)));
            S_DONE:  o_res_valid = 1'b1;
            default: o_ready = 1'b0;
        endcase
    end

    assign o_we    = (r_state == S_IDLE) && is_record;
    assign o_waddr = row_addr(st_idx, cur_wp);
    assign o_wdata = i_duration;

    assign n32         = 32'(r_n);
    assign o_res.stage = r_stage;
    assign o_res.count = n32[COUNT_W-1:0];
    assign o_res.p95   = r_p95;
    assign o_res.p99   = r_p99;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < NUM_STAGES; k++) begin
                r_wp[k]  <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_we) begin
                r_wp[st_idx] <= (int'(cur_wp) == WINDOW - 1) ? '0 : cur_wp + IDX_W'(1);
                if (cur_cnt < CNT_WIN) begin
                    r_cnt[st_idx] <= cur_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    r_st    <= st_idx;
                    r_stage <= i_stage;
                    r_n     <= n_eff;
                    r_base  <= wrap_pos(PW'(cur_wp) + WIN_P - PW'(n_eff));
                    r_qn95  <= C_Q95 * CW'(n_eff);
                    r_qn99  <= C_Q99 * CW'(n_eff);
                    r_i     <= '0;
                    r_p95   <= '0;
                    r_p99   <= '0;
                    r_got95 <= 1'b0;
                    r_got99 <= 1'b0;
                end
            end
            S_CAPV: begin
                r_v    <= i_rdata;
                r_j    <= CNT_W'(1);
                r_less <= '0;
                r_le   <= '0;
            end
            S_SCAN: begin
                r_less <= r_less + CNT_W'(i_rdata < r_v);
                r_le   <= r_le + CNT_W'(i_rdata <= r_v);
                r_j    <= r_j + CNT_W'(1);
            end
            S_JUDGE: begin
                if (!r_got95 && f95) begin
                    r_p95   <= r_v;
                    r_got95 <= 1'b1;
                end
                if (!r_got99 && f99) begin
                    r_p99   <= r_v;
                    r_got99 <= 1'b1;
                end
                r_i <= r_i + CNT_W'(1);
            end
            default: r_v <= r_v;
        endcase
    end

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_j != r_n) |=> (r_state == S_SCAN))
        else $error("scan left before the window was walked");

    a_less_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JUDGE) |-> (r_less <= r_le && r_le <= r_n))
        else $error("rank counters out of order");

    a_both_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_n != '0) |-> (r_got95 && r_got99))
        else $error("percentile not selected before result");

    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAND) |-> (r_i < r_n))
        else $error("candidate index beyond kept count");

endmodule

/* rtl/stage_latency_percentile_monitor.sv */
// Top level: stream ports, budget registers, result register and flag compare.
// Record item: written straight into the stage's ring when it is accepted.
// Query item: the single comparator walks the sample memory's one read port once per
// candidate, and the next item is taken only after the result moves to the output register.
// An empty or absent stage goes straight to a result with a kept count of zero, and a
// held result holds off the next item. Reset clears the sequencer state, ring positions,
// counts, budgets and the output valid.
module stage_latency_percentile_monitor #(
    parameter int WINDOW     = 64,
    parameter int NUM_STAGES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // sample duration
    input  logic [2:0]                      s_axis_tuser,  // opcode, stage[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [79:0]                     m_axis_tdata,  // kept count[6:0], p95_us,
                                                           // p99_us, p95_ok, p99_ok, zeros
    input  logic                            i_cfg_we,
    input  logic [slpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slpm_pkg::BUDGET_W-1:0]   i_cfg_wdata
);
    import slpm_pkg::*;

    localparam int DEPTH = NUM_STAGES * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BUDGET_W-1:0] r_b95 [NUM_BUDGET_STAGES];
    logic [BUDGET_W-1:0] r_b99 [NUM_BUDGET_STAGES];

    logic                r_out_valid;
    t_res                r_out;
    logic                r_ok95, r_ok99;

    logic                ready, start, res_valid, res_take;
    t_res                res;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [DUR_W-1:0]    wdata, rdata;
    logic [BUDGET_W-1:0] b95, b99;

    assign s_axis_tready = ready;
    assign start         = s_axis_tvalid && ready;
    assign res_take      = !r_out_valid || m_axis_tready;

    slpm_ctrl #(
        .WINDOW     (WINDOW),
        .NUM_STAGES (NUM_STAGES),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_opcode    (s_axis_tuser[0]),
        .i_stage     (s_axis_tuser[2:1]),
        .i_duration  (s_axis_tdata),
        .o_ready     (ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    slpm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BUDGET_STAGES; k++) begin
                r_b95[k] <= '0;
                r_b99[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIMITER_P95: r_b95[0] <= i_cfg_wdata;
                CFG_LIMITER_P99: r_b99[0] <= i_cfg_wdata;
                CFG_GAIT_P95:    r_b95[1] <= i_cfg_wdata;
                CFG_GAIT_P99:    r_b99[1] <= i_cfg_wdata;
                CFG_BODY_P95:    r_b95[2] <= i_cfg_wdata;
                CFG_BODY_P99:    r_b99[2] <= i_cfg_wdata;
                CFG_SOLVER_P95:  r_b95[3] <= i_cfg_wdata;
                CFG_SOLVER_P99:  r_b99[3] <= i_cfg_wdata;
                default:         r_b95[0] <= r_b95[0];
            endcase
        end
    end

    // a zero budget always passes
    assign b95 = r_b95[res.stage];
    assign b99 = r_b99[res.stage];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out  <= res;
            r_ok95 <= (b95 == '0) || (res.p95 <= b95);
            r_ok99 <= (b99 == '0) || (res.p99 <= b99);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_ok99, r_ok95, r_out.p99, r_out.p95, r_out.count};

endmodule
